>>> rtl/core/spline_point_tangent_eval_defines.svh
// ----------------------------------------------------------------------------
// spline_point_tangent_eval assertion macros
// shared concurrent assertion forms for the curve evaluator
// ----------------------------------------------------------------------------
`ifndef SPLINE_POINT_TANGENT_EVAL_DEFINES_SVH
`define SPLINE_POINT_TANGENT_EVAL_DEFINES_SVH

// same-cycle implication, off during reset
`define SPTE_ASSERT_IMPL(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SPTE_ASSERT_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/spte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spte_pkg
// widths, constants and arithmetic helpers of the spline point/tangent unit
// ----------------------------------------------------------------------------
package spte_pkg;

  localparam int PARAM_BITS = 16;
  localparam int COORD_W    = 32;
  localparam int T_W        = PARAM_BITS + 1;
  localparam int KW         = 35;               // control points after catmull-rom shift
  localparam int DW         = KW + 1;           // difference of two control points
  localparam int PW         = DW + T_W + 1;     // difference times t
  localparam int TW         = DW + 2;           // tangent before saturation
  localparam int SW         = TW + 2;           // saturation input
  localparam int STAGES     = 9;

  localparam logic [T_W-1:0]       T_ONE = T_W'(1) << PARAM_BITS;
  localparam logic signed [PW-1:0] HALF  = PW'(1) <<< (PARAM_BITS - 1);

  // divide by six: bias keeps the dividend positive, then halve and divide by three
  localparam int H_W    = 33;
  localparam int LO_W   = 16;
  localparam int HI_W   = H_W - LO_W;
  localparam logic signed [35:0] DIV_BIAS  = 36'sd6442450944;   // 6 * 2^30
  localparam logic signed [33:0] DIV_UNBIAS = 34'sd1073741824;  // 2^30
  localparam logic [17:0]        RECIP3    = 18'd174763;        // ceil(2^19 / 3)

  localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sd2147483648);

  typedef struct packed {
    logic [15:0]     qh;
    logic [LO_W+1:0] w;
  } div_part_t;

  // floor(x / 3), exact for x below 2^19
  function automatic logic [17:0] div3(input logic [18:0] x);
    logic [36:0] p;
    p = x * RECIP3;
    return p[36:19];
  endfunction

  // first half of the split divide: quotient of the upper bits and the carried remainder
  function automatic div_part_t div3_hi(input logic [H_W-1:0] h);
    logic [HI_W-1:0] hi;
    logic [17:0]     q;
    logic [HI_W-1:0] r;
    div_part_t       o;
    hi   = h[H_W-1:LO_W];
    q    = div3({2'b00, hi});
    r    = hi - HI_W'(q) - HI_W'(q) - HI_W'(q);
    o.qh = q[15:0];
    o.w  = {r[1:0], h[LO_W-1:0]};
    return o;
  endfunction

  // (v - u) * t + half
  function automatic logic signed [PW-1:0] lerp_mul(input logic signed [KW-1:0] u,
                                                    input logic signed [KW-1:0] v,
                                                    input logic [T_W-1:0] t);
    logic signed [DW-1:0]  d;
    logic signed [T_W:0]   ts;
    logic signed [PW-1:0]  p;
    d  = DW'(v) - DW'(u);
    ts = $signed({1'b0, t});
    p  = d * ts;
    return p + HALF;
  endfunction

  // u + floor(p / 2^PARAM_BITS), stays between the two endpoints
  function automatic logic signed [KW-1:0] lerp_fin(input logic signed [KW-1:0] u,
                                                    input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = PW'(u) + (p >>> PARAM_BITS);
    return s[KW-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] y;
    if (x > SAT_MAX) begin
      y = SAT_MAX;
    end else if (x < SAT_MIN) begin
      y = SAT_MIN;
    end else begin
      y = x;
    end
    return y[COORD_W-1:0];
  endfunction

endpackage

>>> rtl/core/spte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spte_if
// valid/ready channels for curve requests and curve results
// ----------------------------------------------------------------------------
interface spte_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [spte_pkg::COORD_W-1:0] p0_x;
  logic signed [spte_pkg::COORD_W-1:0] p0_y;
  logic signed [spte_pkg::COORD_W-1:0] p1_x;
  logic signed [spte_pkg::COORD_W-1:0] p1_y;
  logic signed [spte_pkg::COORD_W-1:0] p2_x;
  logic signed [spte_pkg::COORD_W-1:0] p2_y;
  logic signed [spte_pkg::COORD_W-1:0] p3_x;
  logic signed [spte_pkg::COORD_W-1:0] p3_y;
  logic [spte_pkg::T_W-1:0]            param_t;

  modport source (output valid, req_type, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
                  p3_x, p3_y, param_t, input ready);
  modport sink (input valid, req_type, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
                p3_x, p3_y, param_t, output ready);
endinterface

interface spte_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [spte_pkg::COORD_W-1:0] point_x;
  logic signed [spte_pkg::COORD_W-1:0] point_y;
  logic signed [spte_pkg::COORD_W-1:0] tangent_x;
  logic signed [spte_pkg::COORD_W-1:0] tangent_y;
  logic signed [spte_pkg::COORD_W-1:0] normal_x;
  logic signed [spte_pkg::COORD_W-1:0] normal_y;

  modport source (output valid, point_x, point_y, tangent_x, tangent_y, normal_x,
                  normal_y, input ready);
  modport sink (input valid, point_x, point_y, tangent_x, tangent_y, normal_x,
                normal_y, output ready);
endinterface

>>> rtl/core/spline_point_tangent_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spline_point_tangent_eval
// cubic bezier / catmull-rom point, tangent and normal, nine-stage pipeline
// ----------------------------------------------------------------------------
// channel | dir | content
// req     | in  | mode, four control points (q16.16), t (q1.16, 1.0 = 65536)
// res     | out | point, tangent, normal (q16.16, saturated)
//
// one item per cycle while res.ready is high; the stages are the chain divide-by-six,
// three de casteljau levels (multiply stage + add stage each) and saturation.
// reset clears only the stage valid bits.
// each stage holds its item while the next one is full and stalled; empty
// stages fill, so bubbles close up and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "spline_point_tangent_eval_defines.svh"

module spline_point_tangent_eval (
  input  logic       clk,
  input  logic       rst,
  spte_req_if.sink   req,
  spte_res_if.source res
);

  localparam int NS = spte_pkg::STAGES;
  localparam int CW = spte_pkg::COORD_W;
  localparam int KW = spte_pkg::KW;
  localparam int PW = spte_pkg::PW;
  localparam int TW = spte_pkg::TW;
  localparam int SW = spte_pkg::SW;
  localparam int TB = spte_pkg::T_W;
  localparam int HW = spte_pkg::H_W;

  // stage valid bits and per-stage load enables
  logic [NS-1:0] v;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = res.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign req.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= req.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // axis 0 is x, axis 1 is y
  logic signed [CW-1:0] in_a [2];
  logic signed [CW-1:0] in_b [2];
  logic signed [CW-1:0] in_c [2];
  logic signed [CW-1:0] in_d [2];

  assign in_a[0] = req.p0_x;
  assign in_a[1] = req.p0_y;
  assign in_b[0] = req.p1_x;
  assign in_b[1] = req.p1_y;
  assign in_c[0] = req.p2_x;
  assign in_c[1] = req.p2_y;
  assign in_d[0] = req.p3_x;
  assign in_d[1] = req.p3_y;

  // stage 1: clamp t, biased dividends for the two divide-by-six terms
  logic signed [32:0] dif_c [2];
  logic signed [32:0] dif_b [2];
  logic signed [35:0] m_c [2];
  logic signed [35:0] m_b [2];
  logic [TB-1:0]      t_clamp;

  logic                 s1_type;
  logic [TB-1:0]        s1_t;
  logic signed [CW-1:0] s1_a [2];
  logic signed [CW-1:0] s1_b [2];
  logic signed [CW-1:0] s1_c [2];
  logic signed [CW-1:0] s1_d [2];
  logic [HW-1:0]        s1_hc [2];
  logic [HW-1:0]        s1_hb [2];

  always_comb begin
    t_clamp = (req.param_t > spte_pkg::T_ONE) ? spte_pkg::T_ONE : req.param_t;
    for (int i = 0; i < 2; i++) begin
      dif_c[i] = 33'(in_c[i]) - 33'(in_a[i]);
      dif_b[i] = 33'(in_b[i]) - 33'(in_d[i]);
      m_c[i]   = 36'(dif_c[i]) + 36'sd3 + spte_pkg::DIV_BIAS;
      m_b[i]   = 36'(dif_b[i]) + 36'sd3 + spte_pkg::DIV_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_type <= req.req_type;
      s1_t    <= t_clamp;
      for (int i = 0; i < 2; i++) begin
        s1_a[i]  <= in_a[i];
        s1_b[i]  <= in_b[i];
        s1_c[i]  <= in_c[i];
        s1_d[i]  <= in_d[i];
        s1_hc[i] <= m_c[i][HW:1];
        s1_hb[i] <= m_b[i][HW:1];
      end
    end
  end

  // stage 2: upper-half divide by three
  logic                 s2_type;
  logic [TB-1:0]        s2_t;
  logic signed [CW-1:0] s2_a [2];
  logic signed [CW-1:0] s2_b [2];
  logic signed [CW-1:0] s2_c [2];
  logic signed [CW-1:0] s2_d [2];
  spte_pkg::div_part_t  s2_pc [2];
  spte_pkg::div_part_t  s2_pb [2];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_type <= s1_type;
      s2_t    <= s1_t;
      for (int i = 0; i < 2; i++) begin
        s2_a[i]  <= s1_a[i];
        s2_b[i]  <= s1_b[i];
        s2_c[i]  <= s1_c[i];
        s2_d[i]  <= s1_d[i];
        s2_pc[i] <= spte_pkg::div3_hi(s1_hc[i]);
        s2_pb[i] <= spte_pkg::div3_hi(s1_hb[i]);
      end
    end
  end

  // stage 3: lower-half divide, remove bias, pick the four control points
  logic [17:0]          q_c [2];
  logic [17:0]          q_b [2];
  logic signed [33:0]   six_c [2];
  logic signed [33:0]   six_b [2];
  logic signed [KW-1:0] k0_n [2];
  logic signed [KW-1:0] k1_n [2];
  logic signed [KW-1:0] k2_n [2];
  logic signed [KW-1:0] k3_n [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      q_c[i]   = spte_pkg::div3({1'b0, s2_pc[i].w});
      q_b[i]   = spte_pkg::div3({1'b0, s2_pb[i].w});
      six_c[i] = $signed({2'b00, s2_pc[i].qh, q_c[i][15:0]}) - spte_pkg::DIV_UNBIAS;
      six_b[i] = $signed({2'b00, s2_pb[i].qh, q_b[i][15:0]}) - spte_pkg::DIV_UNBIAS;
      if (s2_type) begin
        k0_n[i] = KW'(s2_b[i]);
        k1_n[i] = KW'(s2_b[i]) + KW'(six_c[i]);
        k2_n[i] = KW'(s2_c[i]) + KW'(six_b[i]);
        k3_n[i] = KW'(s2_c[i]);
      end else begin
        k0_n[i] = KW'(s2_a[i]);
        k1_n[i] = KW'(s2_b[i]);
        k2_n[i] = KW'(s2_c[i]);
        k3_n[i] = KW'(s2_d[i]);
      end
    end
  end

  logic [TB-1:0]        s3_t;
  logic signed [KW-1:0] s3_k0 [2];
  logic signed [KW-1:0] s3_k1 [2];
  logic signed [KW-1:0] s3_k2 [2];
  logic signed [KW-1:0] s3_k3 [2];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_t <= s2_t;
      for (int i = 0; i < 2; i++) begin
        s3_k0[i] <= k0_n[i];
        s3_k1[i] <= k1_n[i];
        s3_k2[i] <= k2_n[i];
        s3_k3[i] <= k3_n[i];
      end
    end
  end

  // stages 4-5: first de casteljau level
  logic [TB-1:0]        s4_t;
  logic signed [KW-1:0] s4_k0 [2];
  logic signed [KW-1:0] s4_k1 [2];
  logic signed [KW-1:0] s4_k2 [2];
  logic signed [PW-1:0] s4_pab [2];
  logic signed [PW-1:0] s4_pbc [2];
  logic signed [PW-1:0] s4_pcd [2];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_t <= s3_t;
      for (int i = 0; i < 2; i++) begin
        s4_k0[i]  <= s3_k0[i];
        s4_k1[i]  <= s3_k1[i];
        s4_k2[i]  <= s3_k2[i];
        s4_pab[i] <= spte_pkg::lerp_mul(s3_k0[i], s3_k1[i], s3_t);
        s4_pbc[i] <= spte_pkg::lerp_mul(s3_k1[i], s3_k2[i], s3_t);
        s4_pcd[i] <= spte_pkg::lerp_mul(s3_k2[i], s3_k3[i], s3_t);
      end
    end
  end

  logic [TB-1:0]        s5_t;
  logic signed [KW-1:0] s5_ab [2];
  logic signed [KW-1:0] s5_bc [2];
  logic signed [KW-1:0] s5_cd [2];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_t <= s4_t;
      for (int i = 0; i < 2; i++) begin
        s5_ab[i] <= spte_pkg::lerp_fin(s4_k0[i], s4_pab[i]);
        s5_bc[i] <= spte_pkg::lerp_fin(s4_k1[i], s4_pbc[i]);
        s5_cd[i] <= spte_pkg::lerp_fin(s4_k2[i], s4_pcd[i]);
      end
    end
  end

  // stages 6-7: second level
  logic [TB-1:0]        s6_t;
  logic signed [KW-1:0] s6_ab [2];
  logic signed [KW-1:0] s6_bc [2];
  logic signed [PW-1:0] s6_pabc [2];
  logic signed [PW-1:0] s6_pbcd [2];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_t <= s5_t;
      for (int i = 0; i < 2; i++) begin
        s6_ab[i]   <= s5_ab[i];
        s6_bc[i]   <= s5_bc[i];
        s6_pabc[i] <= spte_pkg::lerp_mul(s5_ab[i], s5_bc[i], s5_t);
        s6_pbcd[i] <= spte_pkg::lerp_mul(s5_bc[i], s5_cd[i], s5_t);
      end
    end
  end

  logic [TB-1:0]        s7_t;
  logic signed [KW-1:0] s7_abc [2];
  logic signed [KW-1:0] s7_bcd [2];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_t <= s6_t;
      for (int i = 0; i < 2; i++) begin
        s7_abc[i] <= spte_pkg::lerp_fin(s6_ab[i], s6_pabc[i]);
        s7_bcd[i] <= spte_pkg::lerp_fin(s6_bc[i], s6_pbcd[i]);
      end
    end
  end

  // stage 8: last level multiply, tangent 3*(bcd-abc)
  logic signed [TW-1:0] tan_d [2];
  logic signed [TW-1:0] tan_n [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      tan_d[i] = TW'(s7_bcd[i]) - TW'(s7_abc[i]);
      tan_n[i] = (tan_d[i] <<< 1) + tan_d[i];
    end
  end

  logic signed [KW-1:0] s8_abc [2];
  logic signed [PW-1:0] s8_p [2];
  logic signed [TW-1:0] s8_tan [2];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < 2; i++) begin
        s8_abc[i] <= s7_abc[i];
        s8_p[i]   <= spte_pkg::lerp_mul(s7_abc[i], s7_bcd[i], s7_t);
        s8_tan[i] <= tan_n[i];
      end
    end
  end

  // stage 9: point and saturation into the output register
  logic signed [CW-1:0] s9_pt [2];
  logic signed [CW-1:0] s9_tn [2];
  logic signed [CW-1:0] s9_ny;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int i = 0; i < 2; i++) begin
        s9_pt[i] <= spte_pkg::sat32(SW'(spte_pkg::lerp_fin(s8_abc[i], s8_p[i])));
        s9_tn[i] <= spte_pkg::sat32(SW'(s8_tan[i]));
      end
      s9_ny <= spte_pkg::sat32(-SW'(s8_tan[0]));
    end
  end

  assign res.valid     = v[NS-1];
  assign res.point_x   = s9_pt[0];
  assign res.point_y   = s9_pt[1];
  assign res.tangent_x = s9_tn[0];
  assign res.tangent_y = s9_tn[1];
  assign res.normal_x  = s9_tn[1];
  assign res.normal_y  = s9_ny;

  `SPTE_ASSERT_NEXT(a_accept_fills, clk, rst, req.valid && req.ready, v[0],
                    "accepted item not in stage 1")
  `SPTE_ASSERT_IMPL(a_t_clamped, clk, rst, v[0], s1_t <= spte_pkg::T_ONE,
                    "t above one in stage 1")
  `SPTE_ASSERT_NEXT(a_stall_holds, clk, rst, v[4] && !en[4], v[4],
                    "stalled item lost in stage 5")
  `SPTE_ASSERT_IMPL(a_normal_neg, clk, rst,
                    res.valid && res.tangent_x != 32'sh8000_0000 &&
                    res.tangent_x != 32'sh7fff_ffff,
                    res.normal_y == -res.tangent_x, "normal y not negated tangent x")

endmodule
